[src/bcsi_pkg.sv]
`timescale 1ns / 1ps

package bcsi_pkg;

  localparam int MAX_BAND  = 8;
  localparam int WORD_W    = 32;
  localparam int QUO_W     = 48;
  localparam int ROOT_W    = 24;
  localparam int IDX_W     = 16;
  localparam int ROW_W     = MAX_BAND * WORD_W;
  localparam int L_DEPTH   = MAX_BAND * MAX_BAND;

  // configuration register indexes
  localparam logic [0:0] REG_BAND_WIDTH   = 1'b0;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic              ovf;
    logic [WORD_W-1:0] val;
  } sat_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [WORD_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[WORD_W-1:0];
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.ovf = 1'b1;
      r.val = 32'h7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.ovf = 1'b1;
      r.val = 32'h8000_0000;
    end
    return r;
  endfunction

endpackage

[src/bcsi_ram.sv]
`timescale 1ns / 1ps

module bcsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/bcsi_div.sv]
`timescale 1ns / 1ps

// rounded fixed-point quotient (n * 2^16 + d/2) / d, one quotient bit per cycle
module bcsi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [31:0]        num_i,
  input  logic [31:0]               den_i,
  output bcsi_pkg::div_rsp_t        rsp_o
);
  import bcsi_pkg::*;

  localparam int STEPS = QUO_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [32:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic [32:0]      rem_sh;
  logic [31:0]      mag;
  logic signed [QUO_W:0] quo_s;
  sat_t             res;

  assign rem_sh = {rem_q[31:0], dvd_q[QUO_W-1]};
  assign mag    = num_i[31] ? (~num_i + 32'd1) : num_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS - 1);
      neg_d  = num_i[31];
      dvd_d  = {mag, 16'd0} + {17'd0, den_i[31:1]};
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        dvd_d = {dvd_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[QUO_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign res   = sat32({{(64-QUO_W-1){quo_s[QUO_W]}}, quo_s});

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = res.ovf;
  assign rsp_o.quo  = res.val;

endmodule

[src/bcsi_sqrt.sv]
`timescale 1ns / 1ps

// floor(sqrt(x * 2^16)), two radicand bits per cycle
module bcsi_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         x_i,
  output bcsi_pkg::sqrt_rsp_t rsp_o
);
  import bcsi_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W - 1);
      rad_d  = {1'b0, x_i[30:0], 16'd0};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

[src/banded_chol_from_subset_inverse.sv]
`timescale 1ns / 1ps

// Banded Cholesky column from a banded subset inverse. Each input word is one column of S
// (diagonal and seven entries below it, signed Q16.16); each output word is one finished
// column of the factor with index, bad_pivot on tuser and the end of the run on tlast. An
// input word may produce zero to eight output words, and the block takes no new input until
// all of them are handed to the output register. Everything runs on one 32x32 multiplier,
// one bit-serial divider and one square-root unit under a sequencer. The divider sets the
// pace: a column of block size b needs b(b-1)/2 + 2b quotients on top of its
// multiply-accumulates and the square root.
module banded_chol_from_subset_inverse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // s_off0 .. s_off7, 32 bits each
  input  logic [bcsi_pkg::ROW_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // col_index[15:0], v_off0 .. v_off7 32 bits each
  output logic [bcsi_pkg::ROW_W+15:0]   m_axis_tdata,
  // bad_pivot, also set when a value saturates
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import bcsi_pkg::*;

  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_NEXT    = 6'd1;
  localparam logic [5:0] ST_J_RD    = 6'd2;
  localparam logic [5:0] ST_J_DIAG  = 6'd3;
  localparam logic [5:0] ST_JK_RD   = 6'd4;
  localparam logic [5:0] ST_JK_M1   = 6'd5;
  localparam logic [5:0] ST_JK_M2   = 6'd6;
  localparam logic [5:0] ST_JK_M3   = 6'd7;
  localparam logic [5:0] ST_JK_M4   = 6'd8;
  localparam logic [5:0] ST_J_PIV   = 6'd9;
  localparam logic [5:0] ST_I_RD    = 6'd10;
  localparam logic [5:0] ST_I_LOAD  = 6'd11;
  localparam logic [5:0] ST_IK_RD   = 6'd12;
  localparam logic [5:0] ST_IK_M1   = 6'd13;
  localparam logic [5:0] ST_IK_M2   = 6'd14;
  localparam logic [5:0] ST_I_DIV   = 6'd15;
  localparam logic [5:0] ST_I_WAIT  = 6'd16;
  localparam logic [5:0] ST_FW_ROW  = 6'd17;
  localparam logic [5:0] ST_FK_RD   = 6'd18;
  localparam logic [5:0] ST_FK_M1   = 6'd19;
  localparam logic [5:0] ST_FK_M2   = 6'd20;
  localparam logic [5:0] ST_FW_ST   = 6'd21;
  localparam logic [5:0] ST_BW_DIV  = 6'd22;
  localparam logic [5:0] ST_BW_WAIT = 6'd23;
  localparam logic [5:0] ST_BK_RD   = 6'd24;
  localparam logic [5:0] ST_BK_M1   = 6'd25;
  localparam logic [5:0] ST_BK_M2   = 6'd26;
  localparam logic [5:0] ST_BW_ST   = 6'd27;
  localparam logic [5:0] ST_SQ_GO   = 6'd28;
  localparam logic [5:0] ST_SQ_WAIT = 6'd29;
  localparam logic [5:0] ST_V_DIV   = 6'd30;
  localparam logic [5:0] ST_V_WAIT  = 6'd31;
  localparam logic [5:0] ST_EMIT    = 6'd32;

  localparam logic [3:0] BAND_MAX = 4'(MAX_BAND);

  // configuration
  logic [3:0]  band_q;
  logic [15:0] ccount_q;

  // sequencer control
  logic [5:0]  state_q, state_d;
  logic [15:0] recv_q, recv_d;
  logic [15:0] emitted_q, emitted_d;
  logic        end_q, end_d;
  logic [3:0]  bw_q, bw_d;
  logic [3:0]  b_q, b_d;
  logic [15:0] start_q, start_d;
  logic [3:0]  j_q, j_d;
  logic [3:0]  i_q, i_d;
  logic [3:0]  k_q, k_d;
  logic        flag_q, flag_d;
  logic        bad_q, bad_d;

  // datapath
  logic signed [55:0] acc_q, acc_d;
  logic [31:0]        lval_q, lval_d;
  logic [31:0]        s_q, s_d;
  logic signed [63:0] mul_q;
  logic signed [31:0] ma, mb;
  logic signed [31:0] dv_q [MAX_BAND];
  logic signed [31:0] w_q  [MAX_BAND];
  logic signed [31:0] y_q  [MAX_BAND];
  logic signed [31:0] x_q  [MAX_BAND];
  logic [31:0]        v_q  [MAX_BAND];
  logic               dv_we, w_we, y_we, x_we, v_we, v_clr;
  logic [2:0]         arr_idx;
  logic [31:0]        arr_val;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [ROW_W+15:0]   out_data_q, out_data_d;
  logic                out_user_q, out_user_d;
  logic                out_last_q, out_last_d;
  logic                out_load;

  // memories
  logic               win_we;
  logic [2:0]         win_raddr;
  logic [ROW_W-1:0]   win_rdata;
  logic               l_we;
  logic [5:0]         l_waddr, l_raddr;
  logic [31:0]        l_rdata;

  // shared units
  logic               div_start;
  logic signed [31:0] div_num;
  logic [31:0]        div_den;
  div_rsp_t           div_rsp;
  logic               sq_start;
  sqrt_rsp_t          sq_rsp;

  // helpers
  logic signed [63:0] prod_sum;
  logic signed [47:0] prod_rnd;
  logic signed [55:0] acc_minus;
  sat_t               acc_sat;
  sat_t               prod_sat;
  logic [2:0]         row_j;
  logic [2:0]         win_off;
  logic signed [31:0] win_word;
  logic [15:0]        recv_inc;
  logic [15:0]        n_eff;
  logic [3:0]         bw_eff;
  logic [15:0]        avail;

  assign prod_sum  = mul_q + 64'sd32768;
  assign prod_rnd  = prod_sum[63:16];
  assign acc_minus = acc_q - {{8{prod_rnd[47]}}, prod_rnd};
  assign acc_sat   = sat32({{8{acc_q[55]}}, acc_q});
  assign prod_sat  = sat32({{16{prod_rnd[47]}}, prod_rnd});
  assign row_j     = start_q[2:0] + j_q[2:0];
  assign win_off   = i_q[2:0] - j_q[2:0];
  assign win_word  = win_rdata[{win_off, 5'd0} +: 32];
  assign recv_inc  = recv_q + 16'd1;
  assign n_eff     = (ccount_q == 16'd0) ? 16'd1 : ccount_q;
  assign bw_eff    = (band_q == 4'd0) ? 4'd1 : ((band_q > BAND_MAX) ? BAND_MAX : band_q);
  assign avail     = recv_q - emitted_q;
  assign out_load  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  bcsi_ram #(.WIDTH(ROW_W), .DEPTH(MAX_BAND)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (recv_q[2:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  bcsi_ram #(.WIDTH(WORD_W), .DEPTH(L_DEPTH)) u_l_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (div_rsp.quo),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  bcsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rsp_o   (div_rsp)
  );

  bcsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (x_q[0]),
    .rsp_o   (sq_rsp)
  );

  always_comb begin
    state_d    = state_q;
    recv_d     = recv_q;
    emitted_d  = emitted_q;
    end_d      = end_q;
    bw_d       = bw_q;
    b_d        = b_q;
    start_d    = start_q;
    j_d        = j_q;
    i_d        = i_q;
    k_d        = k_q;
    flag_d     = flag_q;
    bad_d      = bad_q;
    acc_d      = acc_q;
    lval_d     = lval_q;
    s_d        = s_q;
    m_valid_d  = m_valid_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;
    win_we     = 1'b0;
    win_raddr  = row_j;
    l_we       = 1'b0;
    l_waddr    = {i_q[2:0], j_q[2:0]};
    l_raddr    = {i_q[2:0], k_q[2:0]};
    div_start  = 1'b0;
    div_num    = x_q[i_q[2:0]];
    div_den    = s_q;
    sq_start   = 1'b0;
    ma         = $signed(l_rdata);
    mb         = '0;
    dv_we      = 1'b0;
    w_we       = 1'b0;
    y_we       = 1'b0;
    x_we       = 1'b0;
    v_we       = 1'b0;
    v_clr      = 1'b0;
    arr_idx    = k_q[2:0];
    arr_val    = acc_sat.val;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          win_we  = 1'b1;
          recv_d  = recv_inc;
          end_d   = (recv_inc >= n_eff);
          bw_d    = bw_eff;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((emitted_q < recv_q) && ((avail >= {12'd0, bw_q}) || end_q)) begin
          b_d     = (avail >= {12'd0, bw_q}) ? bw_q : avail[3:0];
          start_d = emitted_q;
          j_d     = 4'd0;
          flag_d  = 1'b0;
          bad_d   = 1'b0;
          v_clr   = 1'b1;
          state_d = ST_J_RD;
        end else begin
          // run over: start the next one from column zero
          if (end_q && (emitted_q == recv_q)) begin
            recv_d    = 16'd0;
            emitted_d = 16'd0;
          end
          state_d = ST_IDLE;
        end
      end
      // ldlt factor, column j
      ST_J_RD: begin
        state_d = ST_J_DIAG;
      end
      ST_J_DIAG: begin
        acc_d   = {{24{win_rdata[31]}}, win_rdata[31:0]};
        k_d     = 4'd0;
        state_d = (j_q == 4'd0) ? ST_J_PIV : ST_JK_RD;
      end
      ST_JK_RD: begin
        l_raddr = {j_q[2:0], k_q[2:0]};
        state_d = ST_JK_M1;
      end
      ST_JK_M1: begin
        lval_d  = l_rdata;
        mb      = dv_q[k_q[2:0]];
        state_d = ST_JK_M2;
      end
      ST_JK_M2: begin
        w_we    = 1'b1;
        arr_val = prod_sat.val;
        flag_d  = flag_q | prod_sat.ovf;
        state_d = ST_JK_M3;
      end
      ST_JK_M3: begin
        ma      = $signed(lval_q);
        mb      = w_q[k_q[2:0]];
        state_d = ST_JK_M4;
      end
      ST_JK_M4: begin
        acc_d   = acc_minus;
        k_d     = k_q + 4'd1;
        state_d = (k_q + 4'd1 < j_q) ? ST_JK_RD : ST_J_PIV;
      end
      ST_J_PIV: begin
        dv_we   = 1'b1;
        arr_idx = j_q[2:0];
        flag_d  = flag_q | acc_sat.ovf;
        if ($signed(acc_sat.val) <= 32'sd0) begin
          bad_d   = 1'b1;
          state_d = ST_EMIT;
        end else if (j_q + 4'd1 < b_q) begin
          i_d     = j_q + 4'd1;
          state_d = ST_I_RD;
        end else begin
          i_d     = 4'd0;
          state_d = ST_FW_ROW;
        end
      end
      ST_I_RD: begin
        state_d = ST_I_LOAD;
      end
      ST_I_LOAD: begin
        acc_d   = {{24{win_word[31]}}, win_word};
        k_d     = 4'd0;
        state_d = (j_q == 4'd0) ? ST_I_DIV : ST_IK_RD;
      end
      ST_IK_RD: begin
        state_d = ST_IK_M1;
      end
      ST_IK_M1: begin
        mb      = w_q[k_q[2:0]];
        state_d = ST_IK_M2;
      end
      ST_IK_M2: begin
        acc_d   = acc_minus;
        k_d     = k_q + 4'd1;
        state_d = (k_q + 4'd1 < j_q) ? ST_IK_RD : ST_I_DIV;
      end
      ST_I_DIV: begin
        div_start = 1'b1;
        div_num   = $signed(acc_sat.val);
        div_den   = dv_q[j_q[2:0]];
        flag_d    = flag_q | acc_sat.ovf;
        state_d   = ST_I_WAIT;
      end
      ST_I_WAIT: begin
        if (div_rsp.done) begin
          l_we   = 1'b1;
          flag_d = flag_q | div_rsp.ovf;
          if (i_q + 4'd1 < b_q) begin
            i_d     = i_q + 4'd1;
            state_d = ST_I_RD;
          end else begin
            j_d     = j_q + 4'd1;
            state_d = ST_J_RD;
          end
        end
      end
      // forward substitution against e1
      ST_FW_ROW: begin
        acc_d   = (i_q == 4'd0) ? 56'sd65536 : 56'sd0;
        k_d     = 4'd0;
        state_d = (i_q == 4'd0) ? ST_FW_ST : ST_FK_RD;
      end
      ST_FK_RD: begin
        state_d = ST_FK_M1;
      end
      ST_FK_M1: begin
        mb      = y_q[k_q[2:0]];
        state_d = ST_FK_M2;
      end
      ST_FK_M2: begin
        acc_d   = acc_minus;
        k_d     = k_q + 4'd1;
        state_d = (k_q + 4'd1 < i_q) ? ST_FK_RD : ST_FW_ST;
      end
      ST_FW_ST: begin
        y_we    = 1'b1;
        arr_idx = i_q[2:0];
        flag_d  = flag_q | acc_sat.ovf;
        if (i_q + 4'd1 < b_q) begin
          i_d     = i_q + 4'd1;
          state_d = ST_FW_ROW;
        end else begin
          i_d     = b_q - 4'd1;
          state_d = ST_BW_DIV;
        end
      end
      // back substitution, scaled by the pivots
      ST_BW_DIV: begin
        div_start = 1'b1;
        div_num   = y_q[i_q[2:0]];
        div_den   = dv_q[i_q[2:0]];
        state_d   = ST_BW_WAIT;
      end
      ST_BW_WAIT: begin
        if (div_rsp.done) begin
          acc_d   = {{24{div_rsp.quo[31]}}, div_rsp.quo};
          flag_d  = flag_q | div_rsp.ovf;
          k_d     = i_q + 4'd1;
          state_d = (i_q + 4'd1 < b_q) ? ST_BK_RD : ST_BW_ST;
        end
      end
      ST_BK_RD: begin
        l_raddr = {k_q[2:0], i_q[2:0]};
        state_d = ST_BK_M1;
      end
      ST_BK_M1: begin
        mb      = x_q[k_q[2:0]];
        state_d = ST_BK_M2;
      end
      ST_BK_M2: begin
        acc_d   = acc_minus;
        k_d     = k_q + 4'd1;
        state_d = (k_q + 4'd1 < b_q) ? ST_BK_RD : ST_BW_ST;
      end
      ST_BW_ST: begin
        x_we    = 1'b1;
        arr_idx = i_q[2:0];
        flag_d  = flag_q | acc_sat.ovf;
        if (i_q == 4'd0) begin
          state_d = ST_SQ_GO;
        end else begin
          i_d     = i_q - 4'd1;
          state_d = ST_BW_DIV;
        end
      end
      ST_SQ_GO: begin
        if (x_q[0] <= 32'sd0) begin
          bad_d   = 1'b1;
          state_d = ST_EMIT;
        end else begin
          sq_start = 1'b1;
          state_d  = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (sq_rsp.done) begin
          s_d     = {{(32-ROOT_W){1'b0}}, sq_rsp.root};
          i_d     = 4'd0;
          state_d = ST_V_DIV;
        end
      end
      ST_V_DIV: begin
        div_start = 1'b1;
        state_d   = ST_V_WAIT;
      end
      ST_V_WAIT: begin
        if (div_rsp.done) begin
          v_we    = 1'b1;
          arr_idx = i_q[2:0];
          arr_val = div_rsp.quo;
          flag_d  = flag_q | div_rsp.ovf;
          if (i_q + 4'd1 < b_q) begin
            i_d     = i_q + 4'd1;
            state_d = ST_V_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          m_valid_d  = 1'b1;
          out_data_d = {v_q[7], v_q[6], v_q[5], v_q[4], v_q[3], v_q[2], v_q[1], v_q[0],
                        start_q};
          out_user_d = bad_q | flag_q;
          out_last_d = end_q && (start_q + 16'd1 == recv_q);
          emitted_d  = start_q + 16'd1;
          state_d    = ST_NEXT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q   <= 4'd1;
      ccount_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BAND_WIDTH:   band_q   <= cfg_data_i[3:0];
        REG_COLUMN_COUNT: ccount_q <= cfg_data_i;
        default:          band_q   <= band_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      recv_q    <= '0;
      emitted_q <= '0;
      end_q     <= 1'b0;
      bw_q      <= 4'd1;
      b_q       <= 4'd1;
      start_q   <= '0;
      j_q       <= '0;
      i_q       <= '0;
      k_q       <= '0;
      flag_q    <= 1'b0;
      bad_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      recv_q    <= recv_d;
      emitted_q <= emitted_d;
      end_q     <= end_d;
      bw_q      <= bw_d;
      b_q       <= b_d;
      start_q   <= start_d;
      j_q       <= j_d;
      i_q       <= i_d;
      k_q       <= k_d;
      flag_q    <= flag_d;
      bad_q     <= bad_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    lval_q     <= lval_d;
    s_q        <= s_d;
    mul_q      <= ma * mb;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
    if (dv_we) dv_q[arr_idx] <= arr_val;
    if (w_we)  w_q[arr_idx]  <= arr_val;
    if (y_we)  y_q[arr_idx]  <= arr_val;
    if (x_we)  x_q[arr_idx]  <= arr_val;
    if (v_clr) begin
      for (int n = 0; n < MAX_BAND; n++) begin
        v_q[n] <= '0;
      end
    end else if (v_we) begin
      v_q[arr_idx] <= arr_val;
    end
  end

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= recv_q)
    else $error("more columns emitted than received");

  a_block_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_q != 4'd0) && (b_q <= BAND_MAX))
    else $error("block size out of range");

  a_emit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (emitted_q == $past(start_q) + 16'd1) && m_valid_q)
    else $error("emitted column count did not follow the loaded word");

  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((recv_q - emitted_q) < {12'd0, BAND_MAX}))
    else $error("too many columns outstanding while idle");

endmodule

[dv/banded_chol_from_subset_inverse_tb.sv]
`timescale 1ns / 1ps

module banded_chol_from_subset_inverse_tb;
  import bcsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 3000;
  localparam int RANDOM_ITEMS   = 340;

  typedef logic [MAX_BAND-1:0][WORD_W-1:0] col_words_t;

  typedef struct packed {
    logic [15:0] col;
    col_words_t  v;
    logic        bad;
    logic        is_last;
  } factor_col_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ROW_W-1:0]      s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ROW_W+15:0]     m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [0:0]            cfg_index_i = REG_BAND_WIDTH;
  logic [15:0]           cfg_data_i = '0;

  banded_chol_from_subset_inverse u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [3:0]  band_reg = 4'd1;
  logic [15:0] count_reg = 16'd1;
  int          win [MAX_BAND*MAX_BAND];
  int unsigned cols_in, cols_out;

  factor_col_t pending_cols [$];
  int          errors, items_sent, cols_checked, bad_seen, runs_ended;
  bit          idle_on;
  int          hold_off, stall_left, idle_cnt;

  function automatic int clip(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  // product rounded to Q16.16, ties toward +inf (arith shift is floor)
  function automatic longint fx_mul(int a, int b);
    return (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
  endfunction

  function automatic int fx_div(int n, int d, inout bit f);
    longint num, mag, q;
    num = longint'(n) * 64'sd65536;
    mag = (num < 0) ? -num : num;
    q = (mag + longint'(d / 2)) / longint'(d);
    return clip((num < 0) ? -q : q, f);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int s_entry(int unsigned start, int r, int c);
    return win[((start + c) % MAX_BAND) * MAX_BAND + (r - c)];
  endfunction

  // ldlt solve of the b-by-b block against e1, then scale by 1/sqrt(x0)
  function automatic bit factor_column(int unsigned start, int b, output col_words_t v);
    int     lf [MAX_BAND][MAX_BAND];
    int     dv [MAX_BAND];
    int     w [MAX_BAND];
    int     y [MAX_BAND];
    int     x [MAX_BAND];
    bit     f;
    longint acc;
    int     s;
    f = 1'b0;
    v = '0;
    for (int j = 0; j < b; j++) begin
      acc = s_entry(start, j, j);
      for (int k = 0; k < j; k++) begin
        w[k] = clip(fx_mul(lf[j][k], dv[k]), f);
        acc -= fx_mul(lf[j][k], w[k]);
      end
      dv[j] = clip(acc, f);
      if (dv[j] <= 0) return 1'b1;
      lf[j][j] = 65536;
      for (int i = j + 1; i < b; i++) begin
        acc = s_entry(start, i, j);
        for (int k = 0; k < j; k++) acc -= fx_mul(lf[i][k], w[k]);
        lf[i][j] = fx_div(clip(acc, f), dv[j], f);
      end
    end
    for (int i = 0; i < b; i++) begin
      acc = (i == 0) ? 65536 : 0;
      for (int k = 0; k < i; k++) acc -= fx_mul(lf[i][k], y[k]);
      y[i] = clip(acc, f);
    end
    for (int i = b - 1; i >= 0; i--) begin
      acc = fx_div(y[i], dv[i], f);
      for (int k = i + 1; k < b; k++) acc -= fx_mul(lf[k][i], x[k]);
      x[i] = clip(acc, f);
    end
    if (x[0] <= 0) return 1'b1;
    s = int'(int_sqrt(longint'(x[0]) << 16));
    for (int i = 0; i < b; i++) v[i] = fx_div(x[i], s, f);
    return f;
  endfunction

  task automatic predict_columns(col_words_t s);
    int          bw, n, cnt, b;
    int unsigned slot, avail;
    bit          run_done;
    factor_col_t r;
    bw = (band_reg < 1) ? 1 : (band_reg > MAX_BAND) ? MAX_BAND : int'(band_reg);
    n = (count_reg < 1) ? 1 : int'(count_reg);
    slot = cols_in % MAX_BAND;
    for (int o = 0; o < MAX_BAND; o++) win[slot*MAX_BAND + o] = s[o];
    cols_in = (cols_in + 1) & 16'hffff;
    run_done = (cols_in >= n);
    cnt = 0;
    while (cnt < 8 && cols_out < cols_in) begin
      avail = cols_in - cols_out;
      if (avail >= bw) b = bw;
      else if (run_done) b = avail;
      else break;
      r.bad = factor_column(cols_out, b, r.v);
      r.col = cols_out[15:0];
      cols_out++;
      r.is_last = run_done && (cols_out == cols_in);
      pending_cols.push_back(r);
      cnt++;
    end
    if (run_done && cols_out == cols_in) begin
      cols_in = 0;
      cols_out = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_column(col_words_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_columns(s);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BAND_WIDTH) band_reg = data[3:0];
    else count_reg = data;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (pending_cols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // diagonally dominant column, so blocks are positive definite
  function automatic col_words_t spd_column();
    col_words_t c;
    c[0] = $urandom_range(5 << 16, 9 << 16);
    for (int o = 1; o < MAX_BAND; o++) c[o] = int'($urandom_range(0, 78642)) - 39321;
    return c;
  endfunction

  function automatic col_words_t noise_column();
    col_words_t c;
    for (int o = 0; o < MAX_BAND; o++) c[o] = $urandom;
    return c;
  endfunction

  function automatic col_words_t fill_column(logic [31:0] w);
    col_words_t c;
    for (int o = 0; o < MAX_BAND; o++) c[o] = w;
    return c;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    factor_col_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      cols_checked++;
      if (m_axis_tuser) bad_seen++;
      if (m_axis_tlast) runs_ended++;
      if (pending_cols.size() == 0) begin
        $error("unexpected word: col_index %0d", m_axis_tdata[15:0]);
        errors++;
      end else begin
        e = pending_cols.pop_front();
        if (m_axis_tdata[15:0] !== e.col) begin
          $error("col_index: expected %0d, actual %0d", e.col, m_axis_tdata[15:0]);
          errors++;
        end
        for (int o = 0; o < MAX_BAND; o++)
          if (m_axis_tdata[16 + o*WORD_W +: WORD_W] !== e.v[o]) begin
            $error("v_off%0d: expected %h, actual %h", o, e.v[o],
                   m_axis_tdata[16 + o*WORD_W +: WORD_W]);
            errors++;
          end
        if (m_axis_tuser !== e.bad) begin
          $error("bad_pivot: expected %b, actual %b", e.bad, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== e.is_last) begin
          $error("last_column: expected %b, actual %b", e.is_last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    // band 1, one column per run straight out of reset
    send_column(fill_column(32'h7fff_ffff));
    send_column(fill_column(32'h8000_0000));
    send_column(fill_column(32'h0000_0000));
    send_column(fill_column(32'h0000_0001));
    send_column(spd_column());
    drain();
  endtask

  task automatic test_directed_bands();
    col_words_t c;
    write_reg(REG_BAND_WIDTH, 16'd8);
    write_reg(REG_COLUMN_COUNT, 16'd9);
    for (int k = 0; k < 9; k++) send_column(spd_column());
    drain();
    // short run: tail columns get smaller blocks
    write_reg(REG_BAND_WIDTH, 16'd3);
    write_reg(REG_COLUMN_COUNT, 16'd2);
    send_column(spd_column());
    send_column(spd_column());
    drain();
    // out-of-range registers: band 15 acts as 8, count 0 acts as 1
    write_reg(REG_BAND_WIDTH, 16'hffff);
    write_reg(REG_COLUMN_COUNT, 16'd0);
    send_column(spd_column());
    drain();
    write_reg(REG_BAND_WIDTH, 16'd0);
    send_column(spd_column());
    drain();
    // negative pivot on the second column, then saturating tiny diagonal
    write_reg(REG_BAND_WIDTH, 16'd2);
    write_reg(REG_COLUMN_COUNT, 16'd4);
    send_column(spd_column());
    c = spd_column();
    c[0] = 32'hfff0_0000;
    send_column(c);
    c = fill_column(32'h7fff_ffff);
    c[0] = 32'h0000_0001;
    send_column(c);
    send_column(noise_column());
    drain();
  endtask

  task automatic test_mid_run_changes();
    write_reg(REG_BAND_WIDTH, 16'd4);
    write_reg(REG_COLUMN_COUNT, 16'hffff);
    for (int k = 0; k < 10; k++) send_column(spd_column());
    drain();
    write_reg(REG_BAND_WIDTH, 16'd2);
    for (int k = 0; k < 3; k++) send_column(spd_column());
    drain();
    // count below what has arrived: next word ends the run
    write_reg(REG_COLUMN_COUNT, 16'd3);
    send_column(spd_column());
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_BAND_WIDTH, 16'd2);
    write_reg(REG_COLUMN_COUNT, 16'd30);
    hold_off = 3000;
    for (int k = 0; k < 30; k++) send_column(spd_column());
    drain();
  endtask

  task automatic test_random_runs();
    int target, bw, n, r;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      bw = (r < 45) ? $urandom_range(1, 2) : (r < 85) ? $urandom_range(3, 5)
                                                     : $urandom_range(6, 8);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      // upper bits of the band register are don't-care
      write_reg(REG_BAND_WIDTH, {12'($urandom_range(0, 4095)), 4'(bw)});
      write_reg(REG_COLUMN_COUNT, 16'(n));
      for (int k = 0; k < n; k++)
        send_column(($urandom_range(0, 9) == 0) ? noise_column() : spd_column());
      drain();
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    cols_checked = 0;
    bad_seen = 0;
    runs_ended = 0;
    idle_on = 1'b1;
    hold_off = 0;
    stall_left = 0;
    idle_cnt = 0;
    cols_in = 0;
    cols_out = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_bands();
    test_mid_run_changes();
    test_backpressure();
    test_random_runs();
    drain();
    $display("sent %0d columns, checked %0d factor columns (%0d flagged bad, %0d runs ended)",
             items_sent, cols_checked, bad_seen, runs_ended);
    $display("bands 1..8 incl. out-of-range writes, mid-run register changes, long output stall");
    if (errors == 0 && pending_cols.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
